@@ rtl/core/sopl_pkg.sv @@
// Package with the operation and status codes of the sorted-or-plain key list.
`timescale 1ns / 1ps
`default_nettype none

package sopl_pkg;

    typedef enum logic [3:0] {
        KIND_ADD      = 4'd0,
        KIND_INSERT   = 4'd1,
        KIND_DELETE   = 4'd2,
        KIND_READ     = 4'd3,
        KIND_SET      = 4'd4,
        KIND_FIND     = 4'd5,
        KIND_MOVE     = 4'd6,
        KIND_EXCHANGE = 4'd7,
        KIND_CLEAR    = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_RANGE     = 3'd2,
        ST_SORTED    = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_SAME      = 3'd5
    } status_t;

    localparam int KIND_W     = 4;
    localparam int POS_W      = 8;
    localparam int KEY_IN_W   = 32;
    localparam int STATUS_W   = 3;
    localparam int PLACED_W   = 8;
    localparam int KEY_OUT_W  = 32;
    localparam int HELD_W     = 9;

endpackage

`default_nettype wire

@@ rtl/core/sopl_if.sv @@
// Valid/ready channel interfaces for the request and result items.
`timescale 1ns / 1ps
`default_nettype none

interface sopl_req_if
    import sopl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    other_position;
    logic [KEY_IN_W-1:0] key;

    modport source (output valid, output kind, output position, output other_position,
                    output key, input ready);
    modport sink (input valid, input kind, input position, input other_position,
                  input key, output ready);
endinterface

interface sopl_rsp_if
    import sopl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PLACED_W-1:0]  where_placed;
    logic [KEY_OUT_W-1:0] key_out;
    logic [HELD_W-1:0]    entries_held;

    modport source (output valid, output status, output where_placed, output key_out,
                    output entries_held, input ready);
    modport sink (input valid, input status, input where_placed, input key_out,
                  input entries_held, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sopl_mem.sv @@
// Entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sopl_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_or_plain_list_table_unit.sv @@
// Top level of the sorted-or-plain key list: sequencer around the entry memory.
//
// Requests arrive on the req channel and each gives exactly one result item on
// the rsp channel; both are valid/ready handshakes. The sorted_mode register
// (sorted_reg) is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// One item is worked at a time. A sorted add runs a binary search over the held
// entries, each probe reading the middle entry and comparing it, then shifts
// the entries at and above the slot one per cycle. Insert, delete, move and
// sorted set likewise shift entries in the memory. Find scans one entry per
// cycle. Every step is bound by the single read port of the entry memory.
// Reset empties the list and clears sorted_mode; the memory itself is not
// cleared, as only entries below the count are ever read.
// A finished result waits in an output register; while it is stalled the block
// may take and work the next item, and holds that one's result until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module sorted_or_plain_list_table_unit
    import sopl_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sopl_req_if.sink   req,
    sopl_rsp_if.source rsp,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + POS_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CMP, S_SET_RD, S_SET_CMP, S_TAKE_RD,
        S_TAKE_GET, S_EX_RD2, S_EX_GET, S_FIND, S_SHIFT, S_FINAL, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic                 sorted_reg;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [POS_W-1:0]     pos_reg, pos_next, pos2_reg, pos2_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]        count_reg, count_next, newcnt_reg, newcnt_next;
    logic [CW-1:0]        lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0]        cur_reg, cur_next, rem_reg, rem_next, fidx_reg, fidx_next;
    logic                 pend_reg, pend_next, up_reg, up_next;
    logic [IW-1:0]        wdst_reg, wdst_next, fin_addr_reg, fin_addr_next;
    logic                 fin_we_reg, fin_we_next;
    logic [KEY_WIDTH-1:0] fin_data_reg, fin_data_next, tmp_reg, tmp_next;
    logic [KEY_WIDTH-1:0] kout_reg, kout_next;
    status_t              status_reg, status_next;
    logic [CW-1:0]        placed_reg, placed_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [PLACED_W-1:0]  out_placed_reg, out_placed_next;
    logic [KEY_OUT_W-1:0] out_key_reg, out_key_next;
    logic [HELD_W-1:0]    out_held_reg, out_held_next;

    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_waddr, mem_raddr;
    logic [KEY_WIDTH-1:0] mem_wdata, mem_rdata;

    sopl_mem #(
        .DEPTH (DEPTH),
        .WIDTH (KEY_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.where_placed = out_placed_reg;
    assign rsp.key_out      = out_key_reg;
    assign rsp.entries_held = out_held_reg;

    always_comb
    begin
        logic [WW-1:0]        pos_w, pos2_w, cnt_w;
        logic [CW-1:0]        pos_c, pos2_c, ins_at, dest, mid;
        logic                 rel_go;
        logic [CW-1:0]        rel_from, rel_to;
        logic [KEY_WIDTH-1:0] rel_data;

        pos_w    = WW'(pos_reg);
        pos2_w   = WW'(pos2_reg);
        cnt_w    = WW'(count_reg);
        pos_c    = CW'(pos_w);
        pos2_c   = CW'(pos2_w);
        ins_at   = (pos_w < cnt_w) ? pos_c : count_reg;
        dest     = lo_reg;
        mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
        rel_go   = 1'b0;
        rel_from = pos_c;
        rel_to   = pos_c;
        rel_data = key_reg;

        state_next      = state_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        pos2_next       = pos2_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        newcnt_next     = newcnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        fidx_next       = fidx_reg;
        pend_next       = pend_reg;
        up_next         = up_reg;
        wdst_next       = wdst_reg;
        fin_addr_next   = fin_addr_reg;
        fin_we_next     = fin_we_reg;
        fin_data_next   = fin_data_reg;
        tmp_next        = tmp_reg;
        kout_next       = kout_reg;
        status_next     = status_reg;
        placed_next     = placed_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_placed_next = out_placed_reg;
        out_key_next    = out_key_reg;
        out_held_next   = out_held_reg;
        mem_we          = 1'b0;
        mem_waddr       = fin_addr_reg;
        mem_wdata       = fin_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = pos_c[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.kind;
                    pos_next    = req.position;
                    pos2_next   = req.other_position;
                    key_next    = KEY_WIDTH'(req.key);
                    status_next = ST_OK;
                    placed_next = '0;
                    kout_next   = '0;
                    fin_we_next = 1'b0;
                    rem_next    = '0;
                    pend_next   = 1'b0;
                    newcnt_next = count_reg;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (kind_reg)
                    KIND_ADD:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (sorted_reg)
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_SRCH_RD;
                        end
                        else
                        begin
                            placed_next   = count_reg;
                            fin_we_next   = 1'b1;
                            fin_addr_next = count_reg[IW-1:0];
                            fin_data_next = key_reg;
                            newcnt_next   = count_reg + 1'b1;
                            state_next    = S_FINAL;
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (sorted_reg)
                        begin
                            status_next = ST_SORTED;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            placed_next   = ins_at;
                            fin_we_next   = 1'b1;
                            fin_addr_next = ins_at[IW-1:0];
                            fin_data_next = key_reg;
                            newcnt_next   = count_reg + 1'b1;
                            up_next       = 1'b1;
                            cur_next      = count_reg - 1'b1;
                            rem_next      = count_reg - ins_at;
                            state_next    = S_SHIFT;
                        end
                    end
                    KIND_DELETE, KIND_READ:
                    begin
                        if (pos_w >= cnt_w)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_TAKE_RD;
                        end
                    end
                    KIND_SET:
                    begin
                        if (pos_w >= cnt_w)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            placed_next   = pos_c;
                            fin_we_next   = 1'b1;
                            fin_addr_next = pos_c[IW-1:0];
                            fin_data_next = key_reg;
                            state_next    = sorted_reg ? S_SET_RD : S_FINAL;
                        end
                    end
                    KIND_FIND:
                    begin
                        status_next = ST_NOT_FOUND;
                        cur_next    = '0;
                        state_next  = S_FIND;
                    end
                    KIND_MOVE, KIND_EXCHANGE:
                    begin
                        if (sorted_reg)
                        begin
                            status_next = ST_SORTED;
                            state_next  = S_DONE;
                        end
                        else if (pos_w >= cnt_w || pos2_w >= cnt_w)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else if (pos_reg == pos2_reg)
                        begin
                            status_next = ST_SAME;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_TAKE_RD;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        newcnt_next = '0;
                        state_next  = S_FINAL;
                    end
                    default:
                    begin
                        state_next = S_FINAL;
                    end
                endcase
            end
            S_SET_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SET_CMP;
            end
            S_SET_CMP:
            begin
                if (mem_rdata == key_reg)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid[IW-1:0];
                    mid_next   = mid;
                    state_next = S_SRCH_CMP;
                end
                else if (kind_reg == KIND_ADD)
                begin
                    placed_next   = lo_reg;
                    fin_we_next   = 1'b1;
                    fin_addr_next = lo_reg[IW-1:0];
                    fin_data_next = key_reg;
                    newcnt_next   = count_reg + 1'b1;
                    up_next       = 1'b1;
                    cur_next      = count_reg - 1'b1;
                    rem_next      = count_reg - lo_reg;
                    state_next    = S_SHIFT;
                end
                else
                begin
                    if (pos_c < lo_reg)
                    begin
                        dest = lo_reg - 1'b1;
                    end
                    placed_next = dest;
                    rel_go      = 1'b1;
                    rel_to      = dest;
                end
            end
            S_SRCH_CMP:
            begin
                if (key_reg < mem_rdata)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = S_SRCH_RD;
            end
            S_TAKE_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_TAKE_GET;
            end
            S_TAKE_GET:
            begin
                priority case (1'b1)
                    kind_reg == KIND_READ:
                    begin
                        kout_next  = mem_rdata;
                        state_next = S_DONE;
                    end
                    kind_reg == KIND_DELETE:
                    begin
                        kout_next   = mem_rdata;
                        newcnt_next = count_reg - 1'b1;
                        up_next     = 1'b0;
                        cur_next    = pos_c + 1'b1;
                        rem_next    = count_reg - 1'b1 - pos_c;
                        state_next  = S_SHIFT;
                    end
                    kind_reg == KIND_MOVE:
                    begin
                        rel_go   = 1'b1;
                        rel_to   = pos2_c;
                        rel_data = mem_rdata;
                    end
                    default:
                    begin
                        tmp_next   = mem_rdata;
                        state_next = S_EX_RD2;
                    end
                endcase
            end
            S_EX_RD2:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pos2_c[IW-1:0];
                state_next = S_EX_GET;
            end
            S_EX_GET:
            begin
                mem_we        = 1'b1;
                mem_waddr     = pos_c[IW-1:0];
                mem_wdata     = mem_rdata;
                fin_we_next   = 1'b1;
                fin_addr_next = pos2_c[IW-1:0];
                fin_data_next = tmp_reg;
                state_next    = S_FINAL;
            end
            S_FIND:
            begin
                if (pend_reg && mem_rdata == key_reg)
                begin
                    status_next = ST_OK;
                    placed_next = fidx_reg;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                end
                else if (cur_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg[IW-1:0];
                    fidx_next = cur_reg;
                    cur_next  = cur_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wdst_reg;
                    mem_wdata = mem_rdata;
                end
                if (rem_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg[IW-1:0];
                    pend_next = 1'b1;
                    wdst_next = up_reg ? IW'(cur_reg + 1'b1) : IW'(cur_reg - 1'b1);
                    cur_next  = up_reg ? (cur_reg - 1'b1) : (cur_reg + 1'b1);
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                mem_we     = fin_we_reg;
                count_next = newcnt_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_placed_next = PLACED_W'(WW'(placed_reg));
                    out_key_next    = KEY_OUT_W'(kout_reg);
                    out_held_next   = HELD_W'(WW'(count_reg));
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rel_go)
        begin
            fin_we_next   = 1'b1;
            fin_addr_next = rel_to[IW-1:0];
            fin_data_next = rel_data;
            if (rel_from > rel_to)
            begin
                up_next  = 1'b1;
                cur_next = rel_from - 1'b1;
                rem_next = rel_from - rel_to;
            end
            else
            begin
                up_next  = 1'b0;
                cur_next = rel_from + 1'b1;
                rem_next = rel_to - rel_from;
            end
            state_next = S_SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sorted_reg    <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                sorted_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        pos2_reg       <= pos2_next;
        key_reg        <= key_next;
        newcnt_reg     <= newcnt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        fidx_reg       <= fidx_next;
        up_reg         <= up_next;
        wdst_reg       <= wdst_next;
        fin_addr_reg   <= fin_addr_next;
        fin_we_reg     <= fin_we_next;
        fin_data_reg   <= fin_data_next;
        tmp_reg        <= tmp_next;
        kout_reg       <= kout_next;
        status_reg     <= status_next;
        placed_reg     <= placed_next;
        out_status_reg <= out_status_next;
        out_placed_reg <= out_placed_next;
        out_key_reg    <= out_key_next;
        out_held_reg   <= out_held_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/sopl_chk.sv @@
// Port-level checker for the key list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sopl_chk
    import sopl_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [KEY_OUT_W-1:0] out_key,
    input wire logic [HELD_W-1:0]    out_held
);

    logic [1:0] open_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_held))
        else $error("Stalled result item changed or vanished.");

    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_held <= HELD_W'(DEPTH))
        else $error("Entry count above depth.");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == 2'd0 |-> !out_valid)
        else $error("Result item with no accepted item.");

    a_two: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == 2'd2 |-> !in_ready)
        else $error("Item taken while two are already open.");

endmodule

bind sorted_or_plain_list_table_unit sopl_chk #(
    .DEPTH (DEPTH)
) u_sopl_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_key   (rsp.key_out),
    .out_held  (rsp.entries_held)
);

`default_nettype wire
